>>> rtl/smat_pkg.sv
// smat_pkg: shared widths, register codes, reset values and status structs
// for the moving-average temperature filter. No dependencies.
package smat_pkg;

  localparam int SAMPLE_W = 12;
  localparam int SUM_W    = 16;
  localparam int TEMP_W   = 20;
  localparam int VREF_W   = 12;
  localparam int V25_W    = 12;
  localparam int SLOPE_W  = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  localparam int FULL_SCALE        = 4095;
  localparam int TEMP_OFFSET_CENTI = 2500;

  // register index codes
  localparam logic [CFG_IDX_W-1:0] REG_VREF  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_V25   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SLOPE = 2'd2;

  localparam logic [VREF_W-1:0]  VREF_RESET  = 12'd3300;
  localparam logic [V25_W-1:0]   V25_RESET   = 12'd760;
  localparam logic [SLOPE_W-1:0] SLOPE_RESET = 10'd400;

  // ring/sum unit -> top
  typedef struct packed {
    logic             done;
    logic [SUM_W-1:0] sum;
  } ring_status_t;

  // temperature unit -> top
  typedef struct packed {
    logic                     valid;
    logic [SUM_W-1:0]         sum;
    logic signed [TEMP_W-1:0] temp;
  } temp_result_t;

endpackage

>>> rtl/smat_ring.sv
// smat_ring: sample ring memory (registered synchronous read) and running sum.
// Depends on smat_pkg.
module smat_ring #(
  parameter int WINDOW = 10
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [smat_pkg::SAMPLE_W-1:0]  sample,
  output smat_pkg::ring_status_t         status
);
  import smat_pkg::*;

  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW - 1);
  localparam logic [4:0] WIN_K = 5'(WINDOW);

  typedef enum logic [1:0] {IDLE, READ, UPDATE} state_t;

  state_t              state;
  logic [SAMPLE_W-1:0] mem [WINDOW];
  logic [SAMPLE_W-1:0] rdata;
  logic [SAMPLE_W-1:0] cur;
  logic [SAMPLE_W-1:0] prime_sample;
  logic [SAMPLE_W-1:0] oldest;
  logic [SLOT_W-1:0]   slot;
  logic                primed;
  logic                wrapped;   // every slot rewritten since priming
  logic [SUM_W-1:0]    sum;
  logic                done;
  logic                wr_en;

  assign wr_en = (state == UPDATE);
  // before the first wrap the slot still holds the priming sample
  assign oldest = wrapped ? rdata : prime_sample;

  // ring memory: read of the current slot, write-back in UPDATE
  always_ff @(posedge clk) begin
    rdata <= mem[slot];
    if (wr_en) begin
      mem[slot] <= cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= IDLE;
      primed  <= 1'b0;
      wrapped <= 1'b0;
      slot    <= '0;
      sum     <= '0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        IDLE: begin
          if (start) begin
            cur <= sample;
            if (!primed) begin
              prime_sample <= sample;
              sum          <= SUM_W'(sample) * SUM_W'(WIN_K);
              primed       <= 1'b1;
              done         <= 1'b1;
            end else begin
              state <= READ;
            end
          end
        end
        READ: begin
          state <= UPDATE;
        end
        UPDATE: begin
          sum  <= sum - SUM_W'(oldest) + SUM_W'(cur);
          done <= 1'b1;
          if (slot == LAST_SLOT) begin
            slot    <= '0;
            wrapped <= 1'b1;
          end else begin
            slot <= slot + 1'b1;
          end
          state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

  assign status.done = done;
  assign status.sum  = sum;

endmodule

>>> rtl/smat_temp.sv
// smat_temp: window sum to centi-degrees; multiply stages, then division by
// the constant scale through a reciprocal product and a remainder fix-up.
// Depends on smat_pkg.
module smat_temp #(
  parameter int WINDOW = 10
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [smat_pkg::SUM_W-1:0]    sum,
  input  logic [smat_pkg::VREF_W-1:0]   vref_mv,
  input  logic [smat_pkg::V25_W-1:0]    v25_mv,
  input  logic [smat_pkg::SLOPE_W-1:0]  slope,
  input  logic                          take,
  output smat_pkg::temp_result_t        result
);
  import smat_pkg::*;

  localparam int P_W     = SUM_W + VREF_W;       // 28
  localparam int N_W     = 2 * TEMP_W;           // numerator width, 40
  localparam int R_W     = TEMP_W + 2;           // remainder before fix-up
  localparam int HI_LSB  = 16;                   // numerator bits dropped for the estimate
  localparam int RECIP_W = 24;
  localparam int EST_W   = (N_W - HI_LSB) + RECIP_W;
  localparam int SCALE = FULL_SCALE * WINDOW;
  localparam int DIVISOR = SCALE * 10;           // below 2^20 over WINDOW range
  localparam logic [SUM_W-1:0]  SCALE_C   = SUM_W'(SCALE);
  localparam logic [TEMP_W-1:0] DIVISOR_C = TEMP_W'(DIVISOR);
  // floor(2^40 / divisor); the estimate falls at most two short of the quotient
  localparam longint RECIP = (longint'(1) << (HI_LSB + RECIP_W)) / longint'(DIVISOR);
  localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP);
  localparam logic [R_W-1:0]     DIV_1X  = R_W'(DIVISOR);
  localparam logic [R_W-1:0]     DIV_2X  = R_W'(2 * DIVISOR);
  // bias K*D keeps the numerator nonnegative, K = 2^(TEMP_W-1)
  localparam logic [N_W-1:0]    OFFSET    = N_W'(DIVISOR) << (TEMP_W - 1);
  localparam int BIAS     = TEMP_OFFSET_CENTI - (1 << (TEMP_W - 1));
  localparam int TEMP_MAX = (1 << (TEMP_W - 1)) - 1;
  localparam int TEMP_MIN = -(1 << (TEMP_W - 1));

  typedef enum logic [2:0] {IDLE, MUL, SCALE_ST, DIV, FINISH, HOLD} state_t;

  state_t                   state;
  logic [SUM_W-1:0]         sum_q;
  logic [SLOPE_W-1:0]       slope_q;
  logic [P_W-1:0]           p_sum;
  logic [P_W-1:0]           p_base;
  logic [N_W-1:0]           num;
  logic [TEMP_W-1:0]        quo;
  logic [R_W-1:0]           rem;
  logic signed [TEMP_W-1:0] temp;

  logic signed [P_W:0]      diff;
  logic signed [N_W:0]      prod;
  logic [EST_W-1:0]         est;
  logic [N_W-1:0]           rem_full;
  logic [1:0]               fix;
  logic signed [TEMP_W+1:0] t_wide;

  always_comb begin
    diff = $signed({1'b0, p_sum}) - $signed({1'b0, p_base});
    prod = (N_W+1)'(diff) * (N_W+1)'($signed({1'b0, slope_q}));
  end

  // quotient estimate from the top numerator bits, then the exact remainder
  assign est      = EST_W'(num[N_W-1:HI_LSB]) * EST_W'(RECIP_C);
  assign rem_full = num - N_W'(quo) * N_W'(DIVISOR_C);

  // remainder stays below three divisors; add back the missed steps
  always_comb begin
    if (rem >= DIV_2X) begin
      fix = 2'd2;
    end else if (rem >= DIV_1X) begin
      fix = 2'd1;
    end else begin
      fix = 2'd0;
    end
  end

  assign t_wide = $signed({2'b00, quo}) + $signed({{TEMP_W{1'b0}}, fix}) +
                  $signed((TEMP_W+2)'(BIAS));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      unique case (state)
        IDLE: begin
          if (start) begin
            sum_q   <= sum;
            slope_q <= slope;
            p_sum   <= P_W'(sum) * P_W'(vref_mv);
            p_base  <= P_W'(v25_mv) * P_W'(SCALE_C);
            state   <= MUL;
          end
        end
        MUL: begin
          num   <= prod[N_W-1:0] + OFFSET;
          state <= SCALE_ST;
        end
        SCALE_ST: begin
          quo   <= est[RECIP_W +: TEMP_W];
          state <= DIV;
        end
        DIV: begin
          rem   <= rem_full[R_W-1:0];
          state <= FINISH;
        end
        FINISH: begin
          if (t_wide > $signed((TEMP_W+2)'(TEMP_MAX))) begin
            temp <= TEMP_W'(TEMP_MAX);
          end else if (t_wide < $signed((TEMP_W+2)'(TEMP_MIN))) begin
            temp <= TEMP_W'(TEMP_MIN);
          end else begin
            temp <= t_wide[TEMP_W-1:0];
          end
          state <= HOLD;
        end
        HOLD: begin
          if (take) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  assign result.valid = (state == HOLD);
  assign result.sum   = sum_q;
  assign result.temp  = temp;

endmodule

>>> rtl/sensor_moving_average_to_temp.sv
// sensor_moving_average_to_temp: boxcar average of converter samples and
// conversion of the window sum to hundredths of a degree.
// One item at a time: a new request is taken only once the previous result has
// moved into the output register, which waits on the ring read-modify-write
// and the four conversion steps (the first sample after reset skips the ring).
// Reset (synchronous, rst high) empties the window and loads register defaults.
module sensor_moving_average_to_temp #(
  parameter int WINDOW = 10
) (
  input  logic                              clk,
  input  logic                              rst,
  // input stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [15:0]                       s_axis_tdata,  // [11:0] sample
  // result stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [39:0]                       m_axis_tdata,  // [15:0] window_sum,
                                                           // [35:16] temp_centi
  // register write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [smat_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [smat_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import smat_pkg::*;

  logic               busy;       // an item is in flight
  logic               in_req;
  logic               res_take;
  logic [VREF_W-1:0]  vref_mv;
  logic [V25_W-1:0]   v25_mv;
  logic [SLOPE_W-1:0] slope;
  ring_status_t       ring_st;
  temp_result_t       res;

  // one item in flight; the output register lets the next request in while
  // the previous result still waits downstream
  assign s_axis_tready = !busy;
  assign in_req        = s_axis_tvalid && s_axis_tready;
  assign res_take      = res.valid && (!m_axis_tvalid || m_axis_tready);
  assign cfg_ready     = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (in_req) begin
      busy <= 1'b1;
    end else if (res_take) begin
      busy <= 1'b0;
    end
  end

  // configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      vref_mv <= VREF_RESET;
      v25_mv  <= V25_RESET;
      slope   <= SLOPE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_VREF:  vref_mv <= cfg_data[VREF_W-1:0];
        REG_V25:   v25_mv  <= cfg_data[V25_W-1:0];
        REG_SLOPE: slope   <= cfg_data[SLOPE_W-1:0];
        default: ;
      endcase
    end
  end

  // ring memory and running sum
  smat_ring #(.WINDOW(WINDOW)) u_ring (
    .clk    (clk),
    .rst    (rst),
    .start  (in_req),
    .sample (s_axis_tdata[SAMPLE_W-1:0]),
    .status (ring_st)
  );

  // sum -> temperature
  smat_temp #(.WINDOW(WINDOW)) u_temp (
    .clk     (clk),
    .rst     (rst),
    .start   (ring_st.done),
    .sum     (ring_st.sum),
    .vref_mv (vref_mv),
    .v25_mv  (v25_mv),
    .slope   (slope),
    .take    (res_take),
    .result  (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_take) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      m_axis_tdata <= {4'b0000, res.temp, res.sum};
    end
  end

endmodule

>>> dv/temp_filter_checker.sv
`timescale 1ns / 100ps
// temp_filter_checker: watches the sample, result and register channels of the
// moving-average temperature filter, predicts each reading and compares. Uses smat_pkg.
module temp_filter_checker #(
  parameter int WINDOW = 10
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  input  logic                            s_axis_tready,
  input  logic [15:0]                     s_axis_tdata,
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic [39:0]                     m_axis_tdata,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [smat_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [smat_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              fail_count,
  output int                              pending
);
  import smat_pkg::*;

  typedef struct packed {
    logic [SUM_W-1:0]         sum;
    logic signed [TEMP_W-1:0] temp;
  } reading_t;

  localparam longint SCALE    = longint'(FULL_SCALE) * WINDOW;
  localparam longint DIVISOR  = SCALE * 10;
  localparam longint TEMP_TOP = (longint'(1) << (TEMP_W - 1)) - 1;
  localparam longint TEMP_BOT = -(longint'(1) << (TEMP_W - 1));

  logic [SAMPLE_W-1:0] window_ring [WINDOW];
  logic [SUM_W-1:0]    window_total;
  int unsigned         next_slot;
  bit                  filled;
  logic [VREF_W-1:0]   vref;
  logic [V25_W-1:0]    v25;
  logic [SLOPE_W-1:0]  slope;
  reading_t            expected_readings [$];
  reading_t            got;
  reading_t            want;
  int                  errors;

  assign fail_count = errors;

  // floor(((sum*vref - v25*4095*W) * slope) / (4095*W*10)) + 25.00 deg
  function automatic logic signed [TEMP_W-1:0] centi_degrees(input logic [SUM_W-1:0] total);
    longint diff;
    longint num;
    longint q;
    diff = longint'(total) * longint'(vref) - longint'(v25) * SCALE;
    num  = diff * longint'(slope);
    q    = num / DIVISOR;
    if ((num % DIVISOR) != 0 && num < 0) q -= 1;
    q += TEMP_OFFSET_CENTI;
    if (q > TEMP_TOP) q = TEMP_TOP;
    if (q < TEMP_BOT) q = TEMP_BOT;
    return q[TEMP_W-1:0];
  endfunction

  // first sample fills the whole window; later ones overwrite the oldest slot
  function automatic reading_t average_in(input logic [SAMPLE_W-1:0] smp);
    reading_t r;
    if (!filled) begin
      foreach (window_ring[i]) window_ring[i] = smp;
      window_total = SUM_W'(smp * WINDOW);
      next_slot    = 0;
      filled       = 1'b1;
    end else begin
      window_total = window_total - window_ring[next_slot] + smp;
      window_ring[next_slot] = smp;
      next_slot = (next_slot + 1 == WINDOW) ? 0 : next_slot + 1;
    end
    r.sum  = window_total;
    r.temp = centi_degrees(window_total);
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      filled       = 1'b0;
      window_total = '0;
      next_slot    = 0;
      vref         = VREF_RESET;
      v25          = V25_RESET;
      slope        = SLOPE_RESET;
      expected_readings.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_VREF:  vref  = cfg_data[VREF_W-1:0];
          REG_V25:   v25   = cfg_data[V25_W-1:0];
          REG_SLOPE: slope = cfg_data[SLOPE_W-1:0];
          default: ;  // unmapped index, no effect
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_readings.push_back(average_in(s_axis_tdata[SAMPLE_W-1:0]));
      if (m_axis_tvalid && m_axis_tready) begin
        got.sum  = m_axis_tdata[15:0];
        got.temp = m_axis_tdata[35:16];
        if (expected_readings.size() == 0) begin
          $display("%0t: unexpected result, sum %0d temp %0d", $time, got.sum,
                   $signed(got.temp));
          errors++;
        end else begin
          want = expected_readings.pop_front();
          if (got.sum !== want.sum) begin
            $display("%0t: window_sum mismatch, expected %0d actual %0d", $time,
                     want.sum, got.sum);
            errors++;
          end
          if (got.temp !== want.temp) begin
            $display("%0t: temp_centi mismatch, expected %0d actual %0d", $time,
                     $signed(want.temp), $signed(got.temp));
            errors++;
          end
        end
      end
    end
    pending <= expected_readings.size();
  end

endmodule

>>> dv/tb.sv
`timescale 1ns / 100ps
// tb: stimulus and verdict for sensor_moving_average_to_temp. Depends on
// smat_pkg, the filter RTL and temp_filter_checker.
module tb;
  import smat_pkg::*;

  localparam int WINDOW     = 10;
  localparam int IDLE_LIMIT = 2000;  // cycles without any request before giving up
  localparam int PHASES     = 9;
  localparam int PHASE_LEN  = 50;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;  // past the register map
  localparam logic [SAMPLE_W-1:0]  FULL_COUNT = 12'hFFF;

  // how a run of random samples is shaped
  typedef enum int {
    BURST_UNIFORM, BURST_FULL, BURST_ZERO, BURST_LOW, BURST_HIGH
  } burst_kind_e;

  logic                  clk;
  logic                  rst;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [15:0]           s_axis_tdata;   // [11:0] sample
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [39:0]           m_axis_tdata;   // [15:0] window_sum, [35:16] temp_centi
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int fail_count;
  int pending;      // readings still owed by the block, registered in the checker
  int quiet_cycles;
  bit steady;       // when set, neither side idles

  sensor_moving_average_to_temp #(.WINDOW(WINDOW)) uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  temp_filter_checker #(.WINDOW(WINDOW)) reading_monitor (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending       (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // mostly back-to-back, some short gaps, the odd long one
  function automatic int pick_gap();
    int roll;
    if (steady) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // register values lean on both ends of the range
  function automatic logic [CFG_DATA_W-1:0] pick_reg();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 2) return '0;
    if (roll < 4) return '1;
    return CFG_DATA_W'($urandom_range(0, 4095));
  endfunction

  // One sample request. tvalid is left high after the handshake so the next
  // request can follow without a bubble; it drops only when a gap is drawn.
  task automatic send_sample(input logic [SAMPLE_W-1:0] smp);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, smp};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // Stop sending and wait for every owed reading. The first edge is always
  // taken so that pending already counts the last request.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // slope_word is the full 12-bit write; only its low 10 bits count
  task automatic set_regs(input logic [CFG_DATA_W-1:0] vref_word,
                          input logic [CFG_DATA_W-1:0] v25_word,
                          input logic [CFG_DATA_W-1:0] slope_word,
                          input bit poke_unused);
    write_reg(REG_VREF, vref_word);
    write_reg(REG_V25, v25_word);
    write_reg(REG_SLOPE, slope_word);
    if (poke_unused) write_reg(REG_UNUSED, pick_reg());
    cfg_valid <= 1'b0;
  endtask

  // Runs of similar samples: constant full scale or zero pins the window sum
  // at its ends, the rest mixes ordinary and near-rail readings.
  task automatic send_random(input int count);
    int left;
    int run;
    burst_kind_e kind;
    logic [SAMPLE_W-1:0] smp;
    left = count;
    while (left > 0) begin
      run  = $urandom_range(1, 2 * WINDOW);
      if (run > left) run = left;
      kind = burst_kind_e'($urandom_range(BURST_UNIFORM, BURST_HIGH));
      for (int i = 0; i < run; i++) begin
        case (kind)
          BURST_FULL: smp = FULL_COUNT;
          BURST_ZERO: smp = '0;
          BURST_LOW:  smp = SAMPLE_W'($urandom_range(0, 63));
          BURST_HIGH: smp = SAMPLE_W'($urandom_range(4032, 4095));
          default:    smp = SAMPLE_W'($urandom_range(0, 4095));
        endcase
        send_sample(smp);
      end
      left -= run;
    end
  endtask

  // result side: ready high for a random burst, then maybe a stall
  initial begin : result_sink
    int burst;
    int gap;
    forever begin
      burst = $urandom_range(1, 12);
      m_axis_tready <= 1'b1;
      repeat (burst) @(posedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  // watchdog: any accepted request on any channel restarts the count
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    steady        = 1'b0;
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    cfg_valid     <= 1'b0;
    cfg_index     <= REG_VREF;
    cfg_data      <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Reset registers. The very first sample primes the whole window with
    // full scale, then rail and alternating-bit patterns walk through it.
    send_sample(FULL_COUNT);
    send_sample(12'h000);
    send_sample(FULL_COUNT);
    send_sample(12'hAAA);
    send_sample(12'h555);
    send_sample(12'h800);
    send_sample(12'h7FF);
    send_sample(12'h001);

    // Hottest corner: top vref, zero offset, top slope (upper data bits set),
    // with a full window of full-scale samples.
    drain_results();
    set_regs(12'hFFF, 12'h000, 12'hFFF, 1'b0);
    for (int i = 0; i < WINDOW; i++) send_sample(FULL_COUNT);

    // Coldest corner: minimal vref and slope, top offset, zeros flowing in.
    // The write past the register map must change nothing.
    drain_results();
    set_regs(12'h001, 12'hFFF, 12'hC01, 1'b1);
    for (int i = 0; i < 7; i++) send_sample(12'h000);

    // Random phases, each one after a full drain so registers change only
    // while the block is idle.
    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      case (p)
        0:       set_regs(12'h000, pick_reg(), 12'h000, 1'b1);  // zero vref and slope
        1:       set_regs(12'hFFF, 12'hFFF, 12'hFFF, 1'b0);
        default: set_regs(pick_reg(), pick_reg(), pick_reg(), 1'($urandom_range(0, 1)));
      endcase
      steady = (p == 3 || p == 6);
      send_random(PHASE_LEN);
    end
    steady = 1'b0;

    drain_results();
    repeat (30) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
